### rtl/rti_pkg.sv
// Shared widths and codes for the ray/triangle hit-test pipeline.
// No dependencies; used by the channel interfaces, the top level and the checker.
package rti_pkg;

  // Coordinate width as read from each 32-bit field.
  localparam int CW   = 32;
  // Field and register width.
  localparam int FW   = 32;
  // Edges and origin-minus-vertex vectors.
  localparam int EW   = CW + 1;
  // Cross product terms and results.
  localparam int HPW  = CW + EW;
  localparam int QPW  = 2 * EW;
  localparam int HW   = HPW + 1;
  localparam int QW   = QPW + 1;
  // Split point of the wide multiplicands.
  localparam int SPL  = 32;
  // Partial products and their three-term sums.
  localparam int PPW  = EW + (QW - SPL) + 1;
  localparam int PSW  = PPW + 2;
  // Dot products.
  localparam int DW   = PSW + SPL;
  // Threshold product t_epsilon * |det|.
  localparam int NCH  = (DW + SPL - 1) / SPL;
  localparam int TDW  = DW + SPL;
  localparam int NDOT = 4;

  // Pipeline depth from input register to output register.
  localparam int DEPTH = 10;

  // Dot product slots.
  localparam logic [1:0] DOT_DET = 2'd0;
  localparam logic [1:0] DOT_U   = 2'd1;
  localparam logic [1:0] DOT_V   = 2'd2;
  localparam logic [1:0] DOT_T   = 2'd3;

  // Configuration register indexes.
  localparam int CIW = 3;
  localparam logic [CIW-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CIW-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CIW-1:0] CFG_ORIGIN_Z    = 3'd2;
  localparam logic [CIW-1:0] CFG_DIRECTION_X = 3'd3;
  localparam logic [CIW-1:0] CFG_DIRECTION_Y = 3'd4;
  localparam logic [CIW-1:0] CFG_DIRECTION_Z = 3'd5;
  localparam logic [CIW-1:0] CFG_DET_EPSILON = 3'd6;
  localparam logic [CIW-1:0] CFG_T_EPSILON   = 3'd7;

  localparam logic [FW-1:0] DET_EPSILON_RST = 32'd28147498;
  localparam logic [FW-1:0] T_EPSILON_RST   = 32'd429;

endpackage

### rtl/rti_if.sv
// Channel interfaces of the ray/triangle hit test: triangle in, hit out, config write.
// Depends on rti_pkg for widths.
interface rti_tri_if;
  import rti_pkg::*;
  logic valid;
  logic ready;
  logic signed [FW-1:0] vertex0_x, vertex0_y, vertex0_z;
  logic signed [FW-1:0] vertex1_x, vertex1_y, vertex1_z;
  logic signed [FW-1:0] vertex2_x, vertex2_y, vertex2_z;
  modport source (output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
                  vertex1_z, vertex2_x, vertex2_y, vertex2_z, input ready);
  modport sink (input valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
                vertex1_z, vertex2_x, vertex2_y, vertex2_z, output ready);
endinterface

interface rti_hit_if;
  logic valid;
  logic ready;
  logic hit;
  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

interface rti_cfg_if;
  import rti_pkg::*;
  logic valid;
  logic ready;
  logic [CIW-1:0] index;
  logic [FW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/ray_triangle_intersect.sv
// Top level of the fixed-point Moller-Trumbore ray/triangle hit test.
// Depends on rti_pkg and the channel interfaces in rti_if.sv.

// The ray is held in eight configuration registers written over cfg_wr; triangles
// stream in on in_tri, one beat per triangle, and each gives one hit beat on out_hit
// in the same order. The block takes one triangle every cycle unless out_hit stalls;
// each result passes through ten register stages, which split every wide product
// into multipliers of about 32 by 32 bits. A stall on out_hit holds the whole
// pipeline, so in_tri.ready follows out_hit.ready whenever the output register
// is full. Configuration is taken at any time but should only change while no
// triangle is in flight.
module ray_triangle_intersect (
  input logic      clk,
  input logic      rst_n,
  rti_tri_if.sink  in_tri,
  rti_hit_if.source out_hit,
  rti_cfg_if.sink  cfg_wr
);
  import rti_pkg::*;

  // Configuration registers.
  logic signed [CW-1:0] org_r [3];
  logic signed [CW-1:0] dir_r [3];
  logic [FW-1:0] det_eps_r, t_eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        dir_r[i] <= '0;
      end
      det_eps_r <= DET_EPSILON_RST;
      t_eps_r   <= T_EPSILON_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_ORIGIN_X:    org_r[0] <= cfg_wr.data[CW-1:0];
        CFG_ORIGIN_Y:    org_r[1] <= cfg_wr.data[CW-1:0];
        CFG_ORIGIN_Z:    org_r[2] <= cfg_wr.data[CW-1:0];
        CFG_DIRECTION_X: dir_r[0] <= cfg_wr.data[CW-1:0];
        CFG_DIRECTION_Y: dir_r[1] <= cfg_wr.data[CW-1:0];
        CFG_DIRECTION_Z: dir_r[2] <= cfg_wr.data[CW-1:0];
        CFG_DET_EPSILON: det_eps_r <= cfg_wr.data;
        CFG_T_EPSILON:   t_eps_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign cfg_wr.ready = 1'b1;

  // Pipeline advance: every stage moves unless the output beat is stuck.
  logic [DEPTH-1:0] vld_r;
  logic adv;
  assign adv = !vld_r[DEPTH-1] || out_hit.ready;
  assign in_tri.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tri.valid};
    end
  end

  // Stage 1: edges and origin offset.
  logic signed [CW-1:0] v0 [3], v1 [3], v2 [3];
  logic signed [EW-1:0] e1_r [3], e2_r [3], s_r [3];

  always_comb begin
    v0[0] = in_tri.vertex0_x[CW-1:0];
    v0[1] = in_tri.vertex0_y[CW-1:0];
    v0[2] = in_tri.vertex0_z[CW-1:0];
    v1[0] = in_tri.vertex1_x[CW-1:0];
    v1[1] = in_tri.vertex1_y[CW-1:0];
    v1[2] = in_tri.vertex1_z[CW-1:0];
    v2[0] = in_tri.vertex2_x[CW-1:0];
    v2[1] = in_tri.vertex2_y[CW-1:0];
    v2[2] = in_tri.vertex2_z[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= EW'(v1[i]) - EW'(v0[i]);
        e2_r[i] <= EW'(v2[i]) - EW'(v0[i]);
        s_r[i]  <= EW'(org_r[i]) - EW'(v0[i]);
      end
    end
  end

  // Stage 2: products of the two cross products h = dir x e2, q = s x e1.
  logic signed [HPW-1:0] hp_r [3][2];
  logic signed [QPW-1:0] qp_r [3][2];
  logic signed [EW-1:0]  e1_2r [3], e2_2r [3], s_2r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        hp_r[i][0] <= HPW'(dir_r[(i+1)%3]) * HPW'(e2_r[(i+2)%3]);
        hp_r[i][1] <= HPW'(dir_r[(i+2)%3]) * HPW'(e2_r[(i+1)%3]);
        qp_r[i][0] <= QPW'(s_r[(i+1)%3]) * QPW'(e1_r[(i+2)%3]);
        qp_r[i][1] <= QPW'(s_r[(i+2)%3]) * QPW'(e1_r[(i+1)%3]);
        e1_2r[i] <= e1_r[i];
        e2_2r[i] <= e2_r[i];
        s_2r[i]  <= s_r[i];
      end
    end
  end

  // Stage 3: cross product differences.
  logic signed [HW-1:0] h_r [3];
  logic signed [QW-1:0] q_r [3];
  logic signed [EW-1:0] e1_3r [3], e2_3r [3], s_3r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        h_r[i] <= HW'(hp_r[i][0]) - HW'(hp_r[i][1]);
        q_r[i] <= QW'(qp_r[i][0]) - QW'(qp_r[i][1]);
        e1_3r[i] <= e1_2r[i];
        e2_3r[i] <= e2_2r[i];
        s_3r[i]  <= s_2r[i];
      end
    end
  end

  // Stage 4: split partial products of det, U, V and T.
  logic signed [SPL:0]      h_lo [3], q_lo [3];
  logic signed [HW-SPL-1:0] h_hi [3];
  logic signed [QW-SPL-1:0] q_hi [3];
  logic signed [PPW-1:0]    pl_r [NDOT][3], ph_r [NDOT][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_lo[i] = $signed({1'b0, h_r[i][SPL-1:0]});
      q_lo[i] = $signed({1'b0, q_r[i][SPL-1:0]});
      h_hi[i] = h_r[i][HW-1:SPL];
      q_hi[i] = q_r[i][QW-1:SPL];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pl_r[DOT_DET][i] <= PPW'(e1_3r[i]) * PPW'(h_lo[i]);
        ph_r[DOT_DET][i] <= PPW'(e1_3r[i]) * PPW'(h_hi[i]);
        pl_r[DOT_U][i]   <= PPW'(s_3r[i]) * PPW'(h_lo[i]);
        ph_r[DOT_U][i]   <= PPW'(s_3r[i]) * PPW'(h_hi[i]);
        pl_r[DOT_V][i]   <= PPW'(dir_r[i]) * PPW'(q_lo[i]);
        ph_r[DOT_V][i]   <= PPW'(dir_r[i]) * PPW'(q_hi[i]);
        pl_r[DOT_T][i]   <= PPW'(e2_3r[i]) * PPW'(q_lo[i]);
        ph_r[DOT_T][i]   <= PPW'(e2_3r[i]) * PPW'(q_hi[i]);
      end
    end
  end

  // Stage 5: sum the three low and the three high partials of each dot product.
  logic signed [PSW-1:0] sl_r [NDOT], sh_r [NDOT];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < NDOT; n++) begin
        sl_r[n] <= PSW'(pl_r[n][0]) + PSW'(pl_r[n][1]) + PSW'(pl_r[n][2]);
        sh_r[n] <= PSW'(ph_r[n][0]) + PSW'(ph_r[n][1]) + PSW'(ph_r[n][2]);
      end
    end
  end

  // Stage 6: join the halves into the full dot products.
  logic signed [DW-1:0] dot_r [NDOT];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < NDOT; n++) begin
        dot_r[n] <= $signed({sh_r[n][DW-SPL-1:0], {SPL{1'b0}}}) + DW'(sl_r[n]);
      end
    end
  end

  // Stage 7: fold the sign of det into U, V, T and test the determinant.
  logic                 dneg;
  logic signed [DW-1:0] dabs, u_f, v_f, t_f;
  logic signed [DW-1:0] dabs_r, u_r, v_r, t_7r;
  logic                 bad_7r;

  always_comb begin
    dneg = dot_r[DOT_DET][DW-1];
    dabs = dneg ? -dot_r[DOT_DET] : dot_r[DOT_DET];
    u_f  = dneg ? -dot_r[DOT_U] : dot_r[DOT_U];
    v_f  = dneg ? -dot_r[DOT_V] : dot_r[DOT_V];
    t_f  = dneg ? -dot_r[DOT_T] : dot_r[DOT_T];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dabs_r <= dabs;
      u_r    <= u_f;
      v_r    <= v_f;
      t_7r   <= t_f;
      bad_7r <= (dabs == '0) || ($signed({{(DW-FW){1'b0}}, det_eps_r}) > dabs);
    end
  end

  // Stage 8: barycentric bounds and the partial products of t_epsilon * |det|.
  logic [NCH*SPL-1:0]   dabs_ext;
  logic signed [DW:0]   uv_sum;
  logic [2*SPL-1:0]     tp_r [NCH];
  logic signed [DW-1:0] t_8r;
  logic                 bad_8r;

  assign dabs_ext = (NCH*SPL)'($unsigned(dabs_r));
  assign uv_sum   = (DW+1)'(u_r) + (DW+1)'(v_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NCH; k++) begin
        tp_r[k] <= (2*SPL)'(t_eps_r) * (2*SPL)'(dabs_ext[k*SPL +: SPL]);
      end
      t_8r   <= t_7r;
      bad_8r <= bad_7r || u_r[DW-1] || (u_r > dabs_r) || v_r[DW-1]
                || (uv_sum > (DW+1)'(dabs_r));
    end
  end

  // Stage 9: sum the threshold partials.
  logic [TDW-1:0]       tsum;
  logic [TDW-1:0]       tthr_r;
  logic signed [DW-1:0] t_9r;
  logic                 bad_9r;

  always_comb begin
    tsum = '0;
    for (int k = 0; k < NCH; k++) begin
      tsum = tsum + (TDW'({tp_r[k]}) << (k*SPL));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tthr_r <= tsum;
      t_9r   <= t_8r;
      bad_9r <= bad_8r;
    end
  end

  // Stage 10: distance test into the output register.
  logic signed [TDW:0] t_sh, thr_s;
  logic                hit_r;

  assign t_sh  = $signed({t_9r[DW-1], t_9r, {SPL{1'b0}}});
  assign thr_s = $signed({1'b0, tthr_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= !bad_9r && (t_sh > thr_s);
    end
  end

  assign out_hit.valid = vld_r[DEPTH-1];
  assign out_hit.hit   = hit_r;

endmodule

### rtl/rti_checker.sv
// Port-level checks on the ray/triangle hit test and their binding to the top level.
// Depends on rti_pkg and on the top level ray_triangle_intersect.
module rti_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);
  import rti_pkg::*;

  // A result beat that is not taken stays offered with the same flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit))
    else $error("result beat dropped or changed while stalled");

  // An empty output register never blocks the input.
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  // A stuck result blocks the input, so nothing enters that could be lost.
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while the output is stuck");

  // Reset empties the pipeline.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_tri.ready),
  .out_valid (out_hit.valid),
  .out_ready (out_hit.ready),
  .out_hit   (out_hit.hit)
);

### test/ray_triangle_intersect_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ray/triangle hit-test pipeline.
// Depends on rti_pkg, the channel interfaces in rti_if.sv and ray_triangle_intersect.
module ray_triangle_intersect_tb;
  import rti_pkg::*;

  typedef struct packed {
    logic signed [FW-1:0] x, y, z;
  } vec_t;

  typedef struct packed {
    vec_t v0, v1, v2;
  } tri_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rti_tri_if tri_ch ();
  rti_hit_if hit_ch ();
  rti_cfg_if cfg_ch ();

  ray_triangle_intersect uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_tri (tri_ch.sink),
    .out_hit(hit_ch.source),
    .cfg_wr (cfg_ch.sink)
  );

  always #1 clk = ~clk;

  // Shadow copy of the ray and thresholds.
  vec_t ray_org, ray_dir;
  logic [FW-1:0] det_eps, t_eps;

  tri_t pending_tris[$];
  logic expected_hits[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   hold_tx = 1'b0;
  bit   hold_rx = 1'b0;
  bit   tx_fire = 1'b0;
  int   rx_hold_cycles = 0;
  localparam int WATCHDOG = 20000;

  // Exact hit test, division free, on 256-bit signed intermediates.
  function automatic logic predict_hit(tri_t t);
    logic signed [255:0] o[3], d[3], a[3], b[3], c[3];
    logic signed [255:0] e1[3], e2[3], s[3], h[3], q[3];
    logic signed [255:0] det, dabs, uu, vv, tt;
    o[0] = ray_org.x; o[1] = ray_org.y; o[2] = ray_org.z;
    d[0] = ray_dir.x; d[1] = ray_dir.y; d[2] = ray_dir.z;
    a[0] = t.v0.x; a[1] = t.v0.y; a[2] = t.v0.z;
    b[0] = t.v1.x; b[1] = t.v1.y; b[2] = t.v1.z;
    c[0] = t.v2.x; c[1] = t.v2.y; c[2] = t.v2.z;
    for (int i = 0; i < 3; i++) begin
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      s[i]  = o[i] - a[i];
    end
    h[0] = d[1] * e2[2] - d[2] * e2[1];
    h[1] = d[2] * e2[0] - d[0] * e2[2];
    h[2] = d[0] * e2[1] - d[1] * e2[0];
    det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
    dabs = (det < 0) ? -det : det;
    if (dabs == 0 || $signed({224'd0, det_eps}) > dabs) return 1'b0;
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    uu = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
    vv = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    tt = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (det < 0) begin
      uu = -uu; vv = -vv; tt = -tt;
    end
    if (uu < 0 || uu > dabs) return 1'b0;
    if (vv < 0 || uu + vv > dabs) return 1'b0;
    return (tt <<< 32) > $signed({224'd0, t_eps}) * dabs;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Record at the rising edge whether the offered triangle beat was taken.
  always @(posedge clk) begin
    tx_fire <= tri_ch.valid && tri_ch.ready;
  end

  // Driver: one triangle beat per handshake, random gaps between beats.
  int tx_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (tx_fire) begin
        expected_hits.push_back(predict_hit(pending_tris.pop_front()));
        tx_gap = gap_len();
      end
      if (tri_ch.valid && !tx_fire) begin
        // hold the offered beat
      end else if (tx_gap > 0) begin
        tx_gap--;
        tri_ch.valid <= 1'b0;
      end else if (pending_tris.size() > 0 && !hold_tx) begin
        tri_ch.valid <= 1'b1;
        {tri_ch.vertex0_x, tri_ch.vertex0_y, tri_ch.vertex0_z,
         tri_ch.vertex1_x, tri_ch.vertex1_y, tri_ch.vertex1_z,
         tri_ch.vertex2_x, tri_ch.vertex2_y, tri_ch.vertex2_z} <= pending_tris[0];
      end else begin
        tri_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver readiness, with a long hold-off counted here when requested.
  int rx_gap = 0;
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      hit_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      hit_ch.ready <= 1'b0;
    end else if (hold_rx) begin
      hit_ch.ready <= 1'b1;
    end else begin
      rx_gap = gap_len();
      hit_ch.ready <= (rx_gap == 0);
    end
  end

  // Monitor: compare each result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((tri_ch.valid && tri_ch.ready) || (hit_ch.valid && hit_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (hit_ch.valid && hit_ch.ready) begin
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected hit beat: hit=%0b", hit_ch.hit);
        end else if (hit_ch.hit !== expected_hits[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("hit mismatch: expected %0b, got %0b", expected_hits[0], hit_ch.hit);
          void'(expected_hits.pop_front());
        end else begin
          void'(expected_hits.pop_front());
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CIW-1:0] idx, logic [FW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_ORIGIN_X:    ray_org.x = val;
      CFG_ORIGIN_Y:    ray_org.y = val;
      CFG_ORIGIN_Z:    ray_org.z = val;
      CFG_DIRECTION_X: ray_dir.x = val;
      CFG_DIRECTION_Y: ray_dir.y = val;
      CFG_DIRECTION_Z: ray_dir.z = val;
      CFG_DET_EPSILON: det_eps = val;
      default:         t_eps = val;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_ray(vec_t org, vec_t dir, logic [FW-1:0] de, logic [FW-1:0] te);
    write_reg(CFG_ORIGIN_X, org.x);
    write_reg(CFG_ORIGIN_Y, org.y);
    write_reg(CFG_ORIGIN_Z, org.z);
    write_reg(CFG_DIRECTION_X, dir.x);
    write_reg(CFG_DIRECTION_Y, dir.y);
    write_reg(CFG_DIRECTION_Z, dir.z);
    write_reg(CFG_DET_EPSILON, de);
    write_reg(CFG_T_EPSILON, te);
  endtask

  // Wait for the pipeline to drain before touching the registers.
  task automatic drain();
    while (pending_tris.size() > 0 || expected_hits.size() > 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
  endtask

  function automatic logic [FW-1:0] rand_coord(int scale);
    case (scale)
      0: return FW'($signed($urandom_range(0, 16)) - 8) <<< 16;
      1: return FW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic vec_t rand_vec(int scale);
    vec_t v;
    v.x = rand_coord(scale); v.y = rand_coord(scale); v.z = rand_coord(scale);
    return v;
  endfunction

  // A triangle built around the point where the ray meets it, so hits are common.
  function automatic tri_t aimed_tri(int scale);
    tri_t t;
    vec_t p;
    int k;
    k = $urandom_range(1, 6);
    p.x = ray_org.x + k * ray_dir.x;
    p.y = ray_org.y + k * ray_dir.y;
    p.z = ray_org.z + k * ray_dir.z;
    t.v0 = p; t.v1 = p; t.v2 = p;
    t.v0.x = p.x - (rand_coord(scale) & 32'h7fffffff) / 2;
    t.v0.y = p.y - (rand_coord(scale) & 32'h7fffffff) / 2;
    t.v1.x = p.x + (rand_coord(scale) & 32'h7fffffff) / 2;
    t.v1.z = p.z + rand_coord(scale) / 4;
    t.v2.y = p.y + (rand_coord(scale) & 32'h7fffffff) / 2;
    t.v2.z = p.z - rand_coord(scale) / 4;
    if ($urandom_range(0, 1)) begin
      t.v1 = t.v2;
      t.v2 = p;
      t.v2.x = p.x + (rand_coord(scale) & 32'h7fffffff) / 2;
    end
    return t;
  endfunction

  function automatic tri_t noise_tri();
    tri_t t;
    int sc;
    sc = $urandom_range(0, 2);
    t.v0 = rand_vec(sc); t.v1 = rand_vec(sc); t.v2 = rand_vec(sc);
    return t;
  endfunction

  localparam logic [FW-1:0] ONE  = 32'h0001_0000;
  localparam logic [FW-1:0] MAXP = 32'h7fff_ffff;
  localparam logic [FW-1:0] MINN = 32'h8000_0000;

  initial begin
    vec_t org, dir;
    tri_t t;
    tri_ch.valid = 1'b0;
    {tri_ch.vertex0_x, tri_ch.vertex0_y, tri_ch.vertex0_z,
     tri_ch.vertex1_x, tri_ch.vertex1_y, tri_ch.vertex1_z,
     tri_ch.vertex2_x, tri_ch.vertex2_y, tri_ch.vertex2_z} = '0;
    hit_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ORIGIN_X;
    cfg_ch.data  = '0;
    ray_org = '0; ray_dir = '0;
    det_eps = DET_EPSILON_RST; t_eps = T_EPSILON_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset ray has zero direction: every triangle is parallel.
    t = '{'{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}};
    pending_tris.push_back(t);
    drain();

    // Ray along +z from z = -1, unit triangles in the z = 0 plane.
    set_ray('{0, 0, -ONE}, '{0, 0, ONE}, 0, 0);
    // Origin at a vertex (u = 0, v = 0), on each edge bound, and u + v = 1.
    pending_tris.push_back('{'{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}});
    pending_tris.push_back('{'{-ONE, 0, 0}, '{0, 0, 0}, '{-ONE, ONE, 0}});
    pending_tris.push_back('{'{0, -ONE, 0}, '{ONE, -ONE, 0}, '{0, 0, 0}});
    pending_tris.push_back('{'{-ONE, 0, 0}, '{0, 0, 0}, '{-ONE, ONE, 0}});
    pending_tris.push_back('{'{-ONE, -ONE, 0}, '{ONE, 0, 0}, '{-ONE, ONE, 0}});
    // Reverse winding (positive determinant).
    pending_tris.push_back('{'{-ONE, -ONE, 0}, '{-ONE, ONE, 0}, '{ONE, -ONE, 0}});
    // Just outside: u < 0, u > 1 and v < 0; then one point well inside.
    pending_tris.push_back('{'{1, 0, 0}, '{ONE, 0, 0}, '{1, ONE, 0}});
    pending_tris.push_back('{'{-ONE, 0, 0}, '{-1, 0, 0}, '{-ONE, ONE, 0}});
    pending_tris.push_back('{'{0, 1, 0}, '{ONE, 1, 0}, '{0, ONE, 0}});
    pending_tris.push_back('{'{-ONE, -ONE, 0}, '{ONE, 1, 0}, '{-ONE, ONE, 0}});
    // Behind the origin, and degenerate (zero determinant).
    pending_tris.push_back('{'{-ONE, -ONE, -2*ONE}, '{ONE, 0, -2*ONE}, '{-ONE, ONE, -2*ONE}});
    pending_tris.push_back('{'{0, 0, 0}, '{ONE, 0, 0}, '{2*ONE, 0, 0}});
    // Triangle through the origin itself (t = 0).
    pending_tris.push_back('{'{-ONE, -ONE, -ONE}, '{ONE, 0, -ONE}, '{-ONE, ONE, -ONE}});
    // Extreme coordinates.
    pending_tris.push_back('{'{MINN, MINN, MINN}, '{MAXP, MINN, MAXP}, '{MINN, MAXP, MAXP}});
    pending_tris.push_back('{'{MAXP, MAXP, MAXP}, '{MINN, MAXP, MINN}, '{MAXP, MINN, MINN}});
    pending_tris.push_back('{'{MINN, MINN, MAXP}, '{MAXP, MINN, MAXP}, '{MINN, MAXP, MAXP}});
    drain();

    // Extreme ray registers and thresholds at their ends.
    set_ray('{MINN, MAXP, MINN}, '{MAXP, MINN, MAXP}, 32'hffff_ffff, 32'hffff_ffff);
    pending_tris.push_back('{'{MAXP, MAXP, MAXP}, '{MINN, MINN, MAXP}, '{MAXP, MINN, MINN}});
    pending_tris.push_back(noise_tri());
    drain();
    set_ray('{0, 0, -ONE}, '{0, 0, ONE}, 32'hffff_ffff, 32'hffff_ffff);
    pending_tris.push_back('{'{-ONE, -ONE, 0}, '{ONE, 0, 0}, '{-ONE, ONE, 0}});
    pending_tris.push_back('{'{-1, -1, 0}, '{1, 0, 0}, '{-1, 1, 0}});
    drain();

    // Random phases with fresh rays; one phase stalls the receiver, one drains fully partway through.
    for (int ph = 0; ph < 10; ph++) begin
      int sc;
      sc = ph % 3;
      org = rand_vec(sc == 2 ? 1 : sc);
      dir = rand_vec(sc == 0 ? 0 : 1);
      if (ph == 9) begin
        org = rand_vec(2); dir = rand_vec(2);
      end
      set_ray(org, dir,
              (ph % 4 == 0) ? 32'd0 : (ph % 4 == 1) ? DET_EPSILON_RST : $urandom,
              (ph % 4 == 2) ? $urandom : (ph % 4 == 3) ? 32'd0 : T_EPSILON_RST);
      if (ph == 3) rx_hold_cycles = 200;
      for (int n = 0; n < 175; n++) begin
        if ($urandom_range(0, 99) < 75)
          pending_tris.push_back(aimed_tri($urandom_range(0, 99) < 85 ? 0 : 1 + (ph % 2)));
        else
          pending_tris.push_back(noise_tri());
        if (ph == 5 && n == 80) begin
          // Let every queued beat go out, then hold the sender until all results are in.
          while (pending_tris.size() > 0) @(posedge clk);
          hold_tx = 1'b1;
          while (expected_hits.size() > 0) @(posedge clk);
          hold_tx = 1'b0;
        end
      end
      drain();
    end

    // No idling on the receiver side for a burst.
    hold_rx = 1'b1;
    for (int n = 0; n < 40; n++) pending_tris.push_back(aimed_tri(0));
    drain();
    hold_rx = 1'b0;

    repeat (DEPTH * 2) @(posedge clk);
    if (mismatches == 0 && expected_hits.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
